// ===== src/dnhl_pkg.sv =====
// ----------------------------------------------------------------------------
// dnhl_pkg
// Shared types, status codes and defaults for the name history list.
// ----------------------------------------------------------------------------
package dnhl_pkg;

  // Default table geometry
  localparam int unsigned NameSlotsDef = 8;
  localparam int unsigned NameBytesDef = 16;

  // Result status codes
  localparam logic [2:0] StEmpty   = 3'd0;
  localparam logic [2:0] StDup     = 3'd1;
  localparam logic [2:0] StAppend  = 3'd2;
  localparam logic [2:0] StReplace = 3'd3;
  localparam logic [2:0] StRead    = 3'd4;

  // Input item modes
  localparam logic ModeChar = 1'b0;
  localparam logic ModeRead = 1'b1;

  // One input item
  typedef struct packed {
    logic       mode;
    logic [7:0] char_value;
    logic       last;
    logic [2:0] entry_index;
    logic [3:0] char_index;
  } dnhl_in_t;

  // One result item
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] names_held;
    logic [7:0] read_char;
  } dnhl_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_char;   // buffer the character of an accepted item
    logic take_read;   // start a table read for an accepted item
    logic slot_clear;  // restart the compare slot counter
    logic slot_next;   // advance the compare slot counter
    logic cmp_read;    // fetch the row of the current compare slot
    logic write_name;  // append or replace with the candidate
    logic set_empty;   // record an empty-name result
    logic set_dup;     // record a duplicate result
    logic load_out;    // move the result into the output register
  } dnhl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cand_empty;
    logic table_empty;
    logic match;
    logic last_slot;
    logic out_free;
  } dnhl_sts_t;

endpackage

// ===== src/dnhl_ram.sv =====
// ----------------------------------------------------------------------------
// dnhl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnhl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dnhl_ctrl.sv =====
// ----------------------------------------------------------------------------
// dnhl_ctrl
// Sequencer for item intake, duplicate search, table update and result hand-off.
// ----------------------------------------------------------------------------
module dnhl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  input  logic                in_last_i,
  output logic                in_stall_o,
  input  dnhl_pkg::dnhl_sts_t sts_i,
  output dnhl_pkg::dnhl_cmd_t cmd_o
);
  import dnhl_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SClose = 3'd1;
  localparam logic [2:0] SCmpRd = 3'd2;
  localparam logic [2:0] SCmpCk = 3'd3;
  localparam logic [2:0] SWrite = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0] state_q, state_d;

  // Accept items only while idle
  assign in_stall_o = (state_q != SIdle);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          if (in_mode_i == ModeRead) begin
            cmd_o.take_read = 1'b1;
            state_d         = SDone;
          end else begin
            cmd_o.take_char = 1'b1;
            if (in_last_i) begin
              state_d = SClose;
            end
          end
        end
      end
      SClose: begin
        if (sts_i.cand_empty) begin
          cmd_o.set_empty = 1'b1;
          state_d         = SDone;
        end else if (sts_i.table_empty) begin
          state_d = SWrite;
        end else begin
          cmd_o.slot_clear = 1'b1;
          state_d          = SCmpRd;
        end
      end
      SCmpRd: begin
        cmd_o.cmp_read = 1'b1;
        state_d        = SCmpCk;
      end
      SCmpCk: begin
        if (sts_i.match) begin
          cmd_o.set_dup = 1'b1;
          state_d       = SDone;
        end else if (sts_i.last_slot) begin
          state_d = SWrite;
        end else begin
          cmd_o.slot_next = 1'b1;
          state_d         = SCmpRd;
        end
      end
      SWrite: begin
        cmd_o.write_name = 1'b1;
        state_d          = SDone;
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/dnhl_dp.sv =====
// ----------------------------------------------------------------------------
// dnhl_dp
// Candidate buffer, circular name table, compare unit and output register.
// ----------------------------------------------------------------------------
module dnhl_dp #(
  parameter int unsigned NameSlots = dnhl_pkg::NameSlotsDef,
  parameter int unsigned NameBytes = dnhl_pkg::NameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dnhl_pkg::dnhl_in_t  in_data_i,
  input  dnhl_pkg::dnhl_cmd_t cmd_i,
  output dnhl_pkg::dnhl_sts_t sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output dnhl_pkg::dnhl_out_t out_data_o
);
  import dnhl_pkg::*;

  localparam int unsigned SlotW = $clog2(NameSlots);
  localparam int unsigned CntW  = $clog2(NameSlots + 1);
  localparam int unsigned LenW  = $clog2(NameBytes);
  localparam int unsigned CharW = $clog2(NameBytes);
  localparam int unsigned RowW  = 8 * NameBytes;
  localparam logic [SlotW:0]  SlotsWide = (SlotW + 1)'(NameSlots);
  localparam logic [CntW-1:0] SlotsCnt  = CntW'(NameSlots);

  typedef logic [NameBytes-1:0][7:0] row_t;

  // Map a logical slot (head-relative sum) onto a physical row
  function automatic logic [SlotW-1:0] wrap_row(input logic [SlotW:0] sum);
    logic [SlotW:0] adj;
    adj = sum;
    if (sum >= SlotsWide) begin
      adj = sum - SlotsWide;
    end
    return adj[SlotW-1:0];
  endfunction

  row_t              cand_q, cand_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              ended_q, ended_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SlotW-1:0]  head_q, head_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [2:0]        res_q, res_d;
  logic              rd_ok_q, rd_ok_d;
  logic [CharW-1:0]  pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  dnhl_out_t         out_q, out_d;

  logic              table_full;
  logic              entry_ok;
  logic              char_ok;
  logic [SlotW-1:0]  rd_addr;
  logic [SlotW-1:0]  wr_addr;
  logic              rd_en;
  logic [RowW-1:0]   rd_data;
  row_t              rd_row;

  assign table_full = (count_q == SlotsCnt);
  assign entry_ok   = (32'(in_data_i.entry_index) < NameSlots) &&
                      (32'(in_data_i.entry_index) < 32'(count_q));
  assign char_ok    = (32'(in_data_i.char_index) < NameBytes);

  // Row addresses: reads by accepted slot or compare slot, writes at tail or head
  always_comb begin
    if (cmd_i.take_read) begin
      rd_addr = wrap_row((SlotW + 1)'(head_q) + (SlotW + 1)'(in_data_i.entry_index));
    end else begin
      rd_addr = wrap_row((SlotW + 1)'(head_q) + (SlotW + 1)'(slot_q));
    end
    if (table_full) begin
      wr_addr = head_q;
    end else begin
      wr_addr = wrap_row((SlotW + 1)'(head_q) + (SlotW + 1)'(count_q));
    end
  end

  assign rd_en = cmd_i.take_read || cmd_i.cmp_read;

  dnhl_ram #(
    .Width(RowW),
    .Depth(NameSlots)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write_name),
    .waddr_i(wr_addr),
    .wdata_i(cand_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign rd_row = row_t'(rd_data);

  // Status toward the controller
  assign sts_o.cand_empty  = (len_q == '0);
  assign sts_o.table_empty = (count_q == '0);
  assign sts_o.match       = (rd_data == cand_q);
  assign sts_o.last_slot   = ((32'(slot_q) + 32'd1) == 32'(count_q));
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  // Candidate buffer: append up to NameBytes-1 characters, stop at a zero, clear on hand-off of a non-read result
  always_comb begin
    cand_d  = cand_q;
    len_d   = len_q;
    ended_d = ended_q;
    if (cmd_i.take_char && !ended_q) begin
      if (in_data_i.char_value == 8'd0) begin
        ended_d = 1'b1;
      end else if (32'(len_q) < NameBytes - 1) begin
        cand_d[len_q] = in_data_i.char_value;
        len_d         = len_q + LenW'(1);
      end
    end
    if (cmd_i.load_out && (res_q != StRead)) begin
      cand_d  = '0;
      len_d   = '0;
      ended_d = 1'b0;
    end
  end

  // Table bookkeeping, compare slot and pending result code
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    slot_d  = slot_q;
    res_d   = res_q;
    rd_ok_d = rd_ok_q;
    pos_d   = pos_q;
    if (cmd_i.slot_clear) begin
      slot_d = '0;
    end else if (cmd_i.slot_next) begin
      slot_d = slot_q + SlotW'(1);
    end
    if (cmd_i.take_read) begin
      res_d   = StRead;
      rd_ok_d = entry_ok && char_ok;
      pos_d   = CharW'(in_data_i.char_index);
    end
    if (cmd_i.set_empty) begin
      res_d = StEmpty;
    end
    if (cmd_i.set_dup) begin
      res_d = StDup;
    end
    if (cmd_i.write_name) begin
      if (table_full) begin
        res_d  = StReplace;
        head_d = wrap_row((SlotW + 1)'(head_q) + (SlotW + 1)'(1));
      end else begin
        res_d   = StAppend;
        count_d = count_q + CntW'(1);
      end
    end
  end

  // Output register: load when free, drop once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.load_out) begin
      out_valid_d      = 1'b1;
      out_d.status     = res_q;
      out_d.names_held = 4'(count_q);
      out_d.read_char  = '0;
      if ((res_q == StRead) && rd_ok_q) begin
        out_d.read_char = rd_row[pos_q];
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= '0;
      len_q       <= '0;
      ended_q     <= 1'b0;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cand_q      <= cand_d;
      len_q       <= len_d;
      ended_q     <= ended_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    res_q   <= res_d;
    rd_ok_q <= rd_ok_d;
    pos_q   <= pos_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/dedup_name_history_list_unit.sv =====
// ----------------------------------------------------------------------------
// dedup_name_history_list_unit
// History list of names with duplicate detection and oldest-first eviction.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per item.
// A character item (mode 0) is buffered; the item with last set closes the
// name, which is then searched against the table and appended, or written
// over the oldest entry when the table is full. A read item (mode 1) returns
// one stored byte. Output channel (out_valid_o / out_stall_i / out_data_o)
// carries one result per closing or read item.
// A character item without last gives no result. A read item starts a table
// row read, and its result is loaded into the output register once that
// register is free. A closing item is checked for an empty name, and its
// name is then searched against the stored names until one matches; each
// search step is one table row read followed by a full-row compare. The
// input stalls after a read or closing item until its result is registered,
// so the next item can be taken in the cycle after. The table is one RAM of
// NameSlots rows kept as a circular list, so eviction moves no data.
// Reset empties the table and the candidate at once; unused rows read zero.
// While the receiver stalls, a finished result holds in the output register;
// character items are still taken, and the next read or closing item is
// taken and then holds the input off until the waiting result is transferred.
// ----------------------------------------------------------------------------
module dedup_name_history_list_unit #(
  parameter int unsigned NameSlots = dnhl_pkg::NameSlotsDef,
  parameter int unsigned NameBytes = dnhl_pkg::NameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dnhl_pkg::dnhl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dnhl_pkg::dnhl_out_t out_data_o
);
  import dnhl_pkg::*;

  dnhl_cmd_t cmd;
  dnhl_sts_t sts;

  dnhl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_mode_i (in_data_i.mode),
    .in_last_i (in_data_i.last),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dnhl_dp #(
    .NameSlots(NameSlots),
    .NameBytes(NameBytes)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending transfer");

  // Datapath acts on input fields only for transferred items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take_char || cmd.take_read) |-> (in_valid_i && !in_stall_o))
    else $error("item consumed without a transfer");

  // At most one table access or hand-off per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_char, cmd.take_read, cmd.cmp_read, cmd.write_name,
              cmd.load_out}))
    else $error("conflicting datapath commands");

  // Only read results carry a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != StRead)) |-> (out_data_o.read_char == 8'd0))
    else $error("nonzero character on a non-read result");

endmodule

// ===== tb/name_history_tracker_pkg.sv =====
// ----------------------------------------------------------------------------
// name_history_tracker_pkg
// Keeps the name table as the block should hold it, predicts the result of
// every accepted item and compares each output transfer against the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
package name_history_tracker_pkg;

  import dnhl_pkg::*;

  localparam int unsigned Slots = NameSlotsDef;
  localparam int unsigned Bytes = NameBytesDef;

  // One stored name, byte i at character position i
  typedef logic [Bytes-1:0][7:0] name_row_t;

  class name_history_tracker;
    name_row_t   rows [Slots];
    name_row_t   partial;
    int unsigned partial_len;
    bit          partial_done;
    int unsigned stored;
    dnhl_out_t   awaited [$];
    int unsigned mismatches;

    function new();
      foreach (rows[s]) rows[s] = '0;
      partial      = '0;
      partial_len  = 0;
      partial_done = 1'b0;
      stored       = 0;
      mismatches   = 0;
    endfunction

    // Resolve a closed name: ignore, flag duplicate, append or evict oldest
    function logic [2:0] settle_name();
      int s;
      if (partial_len == 0) return StEmpty;
      for (s = 0; s < int'(stored); s++) begin
        if (rows[s] == partial) return StDup;
      end
      if (stored < Slots) begin
        rows[stored] = partial;
        stored++;
        return StAppend;
      end
      for (s = 0; s < int'(Slots) - 1; s++) rows[s] = rows[s + 1];
      rows[Slots - 1] = partial;
      return StReplace;
    endfunction

    // Advance the table by one accepted input transfer
    function void note_item(dnhl_in_t it);
      dnhl_out_t res;
      res = '0;
      if (it.mode == ModeRead) begin
        res.status     = StRead;
        res.names_held = 4'(stored);
        if (it.entry_index < Slots && it.char_index < Bytes) begin
          res.read_char = rows[it.entry_index][it.char_index];
        end
        awaited.push_back(res);
        return;
      end
      // Buffer the character until a zero ends the name; drop overflow
      if (!partial_done) begin
        if (it.char_value == 8'd0) begin
          partial_done = 1'b1;
        end else if (partial_len < Bytes - 1) begin
          partial[partial_len] = it.char_value;
          partial_len++;
        end
      end
      if (it.last) begin
        res.status     = settle_name();
        res.names_held = 4'(stored);
        awaited.push_back(res);
        partial      = '0;
        partial_len  = 0;
        partial_done = 1'b0;
      end
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_result(dnhl_out_t got);
      dnhl_out_t want;
      if (awaited.size() == 0) begin
        $error("result with none pending: status %0d, names_held %0d, read_char %0d",
               got.status, got.names_held, got.read_char);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.names_held !== want.names_held) begin
        $error("names_held: expected %0d, got %0d", want.names_held, got.names_held);
        mismatches++;
      end
      if (got.read_char !== want.read_char) begin
        $error("read_char: expected %0d, got %0d", want.read_char, got.read_char);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/dedup_name_history_list_unit_tb.sv =====
// ----------------------------------------------------------------------------
// dedup_name_history_list_unit_tb
// Drives names one character per transfer and read requests into the history
// list, with bursty input and a stalling receiver, and checks every result
// against a table kept in step with the accepted transfers.
// ----------------------------------------------------------------------------
module dedup_name_history_list_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dnhl_pkg::*;
  import name_history_tracker_pkg::*;

  typedef logic [7:0] word_t [$];

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  dnhl_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  dnhl_out_t out_data;

  name_history_tracker tracker = new();

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  bit          hold_wanted = 1'b0;

  dedup_name_history_list_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Record accepted inputs and check accepted results at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) tracker.note_item(in_data);
      if (out_valid && !out_stall) tracker.check_result(out_data);
    end
  end

  // Build a character item; the read fields carry noise
  function automatic dnhl_in_t char_item(logic [7:0] c, logic fin);
    dnhl_in_t it;
    it.mode        = ModeChar;
    it.char_value  = c;
    it.last        = fin;
    it.entry_index = 3'($urandom);
    it.char_index  = 4'($urandom);
    return it;
  endfunction

  // Build a read item; the character fields carry noise
  function automatic dnhl_in_t read_item(logic [2:0] e, logic [3:0] p);
    dnhl_in_t it;
    it.mode        = ModeRead;
    it.char_value  = 8'($urandom);
    it.last        = 1'($urandom);
    it.entry_index = e;
    it.char_index  = p;
    return it;
  endfunction

  // Reads mostly hit the first characters, where names actually live
  function automatic dnhl_in_t random_read();
    logic [3:0] p;
    p = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    return read_item(3'($urandom), p);
  endfunction

  // Offer one transfer, inserting an idle gap, at times none, between bursts
  task automatic offer_item(input dnhl_in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(15, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Send a name, last on its final character, with optional reads inside it
  task automatic send_word(input word_t w, input bit mid_reads);
    int unsigned k;
    for (k = 0; k < w.size(); k++) begin
      if (mid_reads && k != 0 && $urandom_range(0, 99) < 8) offer_item(random_read());
      offer_item(char_item(w[k], k == w.size() - 1));
    end
  endtask

  // Receiver: stall patterns in runs, plus one long hold-off on request
  initial begin : receiver
    int unsigned run;
    int unsigned kind;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        repeat (400) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      kind = $urandom_range(0, 3);
      run  = $urandom_range(4, 60);
      repeat (run) begin
        @(negedge clk);
        case (kind)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    word_t       w;
    int unsigned goal;
    int unsigned len;
    int unsigned pick;
    int unsigned k;
    bit          hold_asked;
    hold_asked = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Unused slots read zero after reset
    offer_item(read_item(3'd0, 4'd0));
    offer_item(read_item(3'd7, 4'd0));
    // Empty name, first append, exact duplicate
    send_word({8'h00}, 1'b0);
    send_word({8'h41}, 1'b0);
    send_word({8'h41}, 1'b0);
    // Characters after a zero are ignored
    send_word({8'h42, 8'h00, 8'h43}, 1'b0);
    // Overlong name with extreme bytes, a read in the middle of it
    for (k = 0; k < 16; k++) begin
      if (k == 5) offer_item(read_item(3'd1, 4'd0));
      offer_item(char_item((k == 0) ? 8'hFF : (k == 1) ? 8'h01 : 8'(8'h70 + k), k == 15));
    end
    offer_item(read_item(3'd3, 4'd14));
    offer_item(read_item(3'd3, 4'd15));

    // Random names over a small alphabet so duplicates and evictions recur
    goal = items_sent + 1350;
    while (items_sent < goal) begin
      if (!hold_asked && items_sent + 1150 > goal) begin
        hold_asked  = 1'b1;
        hold_wanted = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        offer_item(random_read());
      end else if (pick < 26) begin
        send_word({8'h00}, 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        len  = (pick < 70) ? $urandom_range(1, 3) :
               (pick < 90) ? $urandom_range(4, 8) : $urandom_range(9, 20);
        w = {};
        for (k = 0; k < len; k++) begin
          w.push_back(($urandom_range(0, 4) != 0) ? 8'(8'h61 + $urandom_range(0, 2))
                                                   : 8'($urandom));
        end
        send_word(w, 1'b1);
      end
    end

    // Drain: wait for every pending result, then a latency margin
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("dedup_name_history_list_unit regression: pass");
    end else begin
      $display("dedup_name_history_list_unit regression: fail");
    end
    $finish;
  end

  // Run limit
  initial begin : run_limit
    #(5_000_000);
    $display("dedup_name_history_list_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/dnhl_pkg.sv
src/dnhl_ram.sv
src/dnhl_ctrl.sv
src/dnhl_dp.sv
src/dedup_name_history_list_unit.sv
tb/name_history_tracker_pkg.sv
tb/dedup_name_history_list_unit_tb.sv
